@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the slot table.
// Depends on nothing; the user scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define KQST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slot table assertion failed");

// Same-cycle implication built on the macro above.
`define KQST_ASSERT_IMPL(lbl, ante, cons) \
    `KQST_ASSERT(lbl, (ante) |-> (cons))

`endif

@@ rtl/kqst_pkg.sv @@
// Shared widths, codes and default sizes of the keyed quantity slot table.
// Depends on nothing; used by the interfaces, the core and its checker.
package kqst_pkg;

    localparam int KEY_W    = 8;
    localparam int QTY_W    = 16;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 5;
    localparam int CFG_W    = 9;
    // Wide enough to compare a key against the largest allowed key limit.
    localparam int LIMIT_W  = 17;

    localparam int DEF_NUM_SLOTS = 16;
    localparam int DEF_NUM_KEYS  = 256;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD       = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_SHORT     = 3'd4,
        ST_OVERFLOW  = 3'd5
    } status_t;

endpackage

@@ rtl/kqst_if.sv @@
// Valid/ready channel interfaces of the slot table: request, response and
// configuration write. Depends on kqst_pkg for the payload widths.
interface kqst_req_if import kqst_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] item_key;
    logic [QTY_W-1:0] amount;

    modport source (output valid, output op, output item_key, output amount, input ready);
    modport sink   (input valid, input op, input item_key, input amount, output ready);
endinterface

interface kqst_rsp_if import kqst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [QTY_W-1:0]    key_count;
    logic [USED_W-1:0]   used_slots;

    modport source (output valid, output status, output key_count, output used_slots,
                    input ready);
    modport sink   (input valid, input status, input key_count, input used_slots,
                    output ready);
endinterface

interface kqst_cfg_if import kqst_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] item_count;

    modport source (output valid, output item_count, input ready);
    modport sink   (input valid, input item_count, output ready);
endinterface

@@ rtl/keyed_quantity_slot_table_core.sv @@
// Keyed quantity slot table: a fixed set of key/quantity slots that is searched
// one slot per cycle. Depends on kqst_pkg and the channel interfaces in kqst_if.sv.
//
// Usage:
//   req carries one item (op, item_key, amount). It is accepted when valid and
//   ready are both high; ready is high only while the sequencer is idle.
//   rsp carries one result item per request (status, key_count, used_slots).
//   cfg writes item_count; it is always ready and must be written only while
//   no request is in flight.
// Scan order:
//   The slot store is a memory with a registered read port, and a single
//   comparator walks it one slot per cycle. An item is accepted, its slots
//   are read and compared in turn, and its result is then loaded onto rsp;
//   the next item may be accepted in the cycle after the result is loaded,
//   so a new item is not taken while the last one is still being scanned.
//   The scan length is set by the one memory read port.
// Stall behavior:
//   The result sits in an output register. A new item is accepted while it
//   waits, but that item's update is held back in its final step until the
//   output register is free, so nothing is lost or reordered.
// Reset:
//   rst_n clears every slot's occupied bit, the slot count and item_count
//   (to 1). The memory itself is not cleared; data of empty slots is never used.
module keyed_quantity_slot_table_core
    import kqst_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int NUM_KEYS  = DEF_NUM_KEYS
)(
    input  logic       clk,
    input  logic       rst_n,
    kqst_cfg_if.sink   cfg,
    kqst_req_if.sink   req,
    kqst_rsp_if.source rsp
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NUM_SLOTS - 1);
    localparam logic [LIMIT_W-1:0] KEY_LIMIT = LIMIT_W'(NUM_KEYS);

    // A slot word as it is kept in the memory.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [QTY_W-1:0] qty;
    } slot_t;

    // The scan issues one read per cycle; the compare runs on the registered
    // read data in the cycle after each read. DECIDE applies the update and
    // loads the result.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    item_count_reg;
    op_t                 op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [QTY_W-1:0]    amount_reg;

    logic [IDX_W-1:0]    rd_idx_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                cmp_vld_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [QTY_W-1:0]    hit_qty_reg;
    logic                free_reg;
    logic [IDX_W-1:0]    free_idx_reg;

    logic [NUM_SLOTS-1:0] occ_reg;
    logic [CNT_W-1:0]    used_reg;

    logic                rsp_valid_reg;
    status_t             rsp_status_reg;
    logic [QTY_W-1:0]    rsp_count_reg;
    logic [CNT_W-1:0]    rsp_used_reg;

    slot_t               slot_mem [NUM_SLOTS];
    slot_t               mem_rd_reg;

    logic                req_fire;
    logic                rsp_free;
    logic                commit;
    logic [IDX_W-1:0]    rd_addr;
    logic                cmp_occ;
    logic                cmp_match;

    logic [QTY_W:0]      sum;
    logic [QTY_W-1:0]    diff;
    logic                add_bad;
    status_t             status_next;
    logic [QTY_W-1:0]    count_next;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    slot_t               wr_data;
    logic                occ_set;
    logic                occ_clr;
    logic [CNT_W-1:0]    used_next;
    logic [CNT_W+USED_W-1:0] used_ext;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign commit    = (state_reg == S_DECIDE) && rsp_free;

    // Slot 0 is read in the accept cycle so the scan starts without a bubble.
    assign rd_addr = (state_reg == S_IDLE) ? '0 : rd_idx_reg;

    assign cmp_occ   = occ_reg[cmp_idx_reg];
    assign cmp_match = cmp_occ && (mem_rd_reg.key == key_reg) && (key_reg != '0);

    // Final decision for the item, from what the scan found.
    always_comb
    begin
        sum     = {1'b0, hit_qty_reg} + {1'b0, amount_reg};
        diff    = hit_qty_reg - amount_reg;
        add_bad = (key_reg == '0)
               || ({1'b0, key_reg} >= item_count_reg)
               || ({{(LIMIT_W-KEY_W){1'b0}}, key_reg} >= KEY_LIMIT)
               || (amount_reg == '0);

        status_next = ST_OK;
        count_next  = hit_reg ? hit_qty_reg : '0;
        wr_en       = 1'b0;
        wr_idx      = hit_idx_reg;
        wr_data     = '{key: key_reg, qty: amount_reg};
        occ_set     = 1'b0;
        occ_clr     = 1'b0;

        unique case (op_reg)
            OP_ADD:
            begin
                priority if (add_bad)
                begin
                    status_next = ST_BAD;
                end
                else if (hit_reg)
                begin
                    if (sum[QTY_W])
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_data.qty = sum[QTY_W-1:0];
                        count_next  = sum[QTY_W-1:0];
                    end
                end
                else if (free_reg)
                begin
                    wr_en      = 1'b1;
                    wr_idx     = free_idx_reg;
                    occ_set    = 1'b1;
                    count_next = amount_reg;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                priority if (key_reg == '0)
                begin
                    status_next = ST_BAD;
                end
                else if (!hit_reg)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else if (hit_qty_reg < amount_reg)
                begin
                    status_next = ST_SHORT;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_data.qty = diff;
                    count_next  = diff;
                    // A slot that drops to zero is freed.
                    occ_clr     = (diff == '0);
                end
            end
            OP_QUERY:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_BAD;
            end
        endcase

        used_next = used_reg + CNT_W'(occ_set) - CNT_W'(occ_clr);
    end

    // Slot memory: one write port used in DECIDE, one registered read port.
    always_ff @(posedge clk)
    begin
        if (commit && wr_en)
        begin
            slot_mem[wr_idx] <= wr_data;
        end
        mem_rd_reg <= slot_mem[rd_addr];
    end

    // Sequencer, scan bookkeeping, slot occupancy and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_count_reg <= CFG_W'(1);
            cmp_vld_reg    <= 1'b0;
            occ_reg        <= '0;
            used_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                item_count_reg <= cfg.item_count;
            end

            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // One slot compared per cycle.
            if (cmp_vld_reg)
            begin
                if (cmp_match && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= cmp_idx_reg;
                    hit_qty_reg <= mem_rd_reg.qty;
                end
                if (!cmp_occ && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= cmp_idx_reg;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    cmp_vld_reg <= 1'b0;
                    if (req_fire)
                    begin
                        op_reg      <= op_t'(req.op);
                        key_reg     <= req.item_key;
                        amount_reg  <= req.amount;
                        hit_reg     <= 1'b0;
                        free_reg    <= 1'b0;
                        cmp_idx_reg <= '0;
                        cmp_vld_reg <= 1'b1;
                        rd_idx_reg  <= IDX_W'(1);
                        state_reg   <= (NUM_SLOTS > 1) ? S_SCAN : S_DRAIN;
                    end
                end
                S_SCAN:
                begin
                    cmp_idx_reg <= rd_idx_reg;
                    cmp_vld_reg <= 1'b1;
                    rd_idx_reg  <= rd_idx_reg + IDX_W'(1);
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    cmp_vld_reg <= 1'b0;
                    state_reg   <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (rsp_free)
                    begin
                        if (occ_set)
                        begin
                            occ_reg[wr_idx] <= 1'b1;
                        end
                        if (occ_clr)
                        begin
                            occ_reg[wr_idx] <= 1'b0;
                        end
                        used_reg       <= used_next;
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= status_next;
                        rsp_count_reg  <= count_next;
                        rsp_used_reg   <= used_next;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The slot count is reported in its low bits only.
    assign used_ext = (CNT_W+USED_W)'(rsp_used_reg);

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.key_count  = rsp_count_reg;
    assign rsp.used_slots = used_ext[USED_W-1:0];

endmodule

@@ rtl/kqst_checker.sv @@
// Port-level checker for the slot table core, attached by the bind below.
// Depends on kqst_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module kqst_checker
    import kqst_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [QTY_W-1:0]    rsp_key_count,
    input logic [USED_W-1:0]   rsp_used_slots
);

    // A result that is not taken stays offered.
    `KQST_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid)

    // The block is busy for the scan after it takes an item.
    `KQST_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready)

    // A full table reports every slot in use.
    `KQST_ASSERT_IMPL(a_full_means_all_used, rsp_valid && (rsp_status == ST_FULL),
        rsp_used_slots == USED_W'(NUM_SLOTS))

    // A key that was not found holds nothing.
    `KQST_ASSERT_IMPL(a_not_found_zero, rsp_valid && (rsp_status == ST_NOT_FOUND),
        rsp_key_count == '0)

    // The slot count never passes the number of slots.
    `KQST_ASSERT_IMPL(a_used_bound, rsp_valid,
        (NUM_SLOTS > 31) || (rsp_used_slots <= NUM_SLOTS))

endmodule

bind keyed_quantity_slot_table_core kqst_checker #(
    .NUM_SLOTS (NUM_SLOTS)
) u_kqst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_key_count  (rsp.key_count),
    .rsp_used_slots (rsp.used_slots)
);
